>>> src/rru_pkg.sv
`timescale 1ns / 1ps

package rru_pkg;

	localparam int OP_W   = 3;
	localparam int ARCH_W = 5;
	localparam int PHYS_W = 6;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC    = 3'd0,
		OP_COMPLETE = 3'd1,
		OP_RETIRE   = 3'd2,
		OP_ROLLBACK = 3'd3,
		OP_QUERY    = 3'd4
	} op_t;

	typedef struct packed {
		logic              accepted;
		logic [PHYS_W-1:0] src_phys;
		logic [PHYS_W-1:0] dest_phys;
		logic [PHYS_W-1:0] prev_phys;
		logic              dest_given;
		logic              is_ready;
	} rsp_t;

endpackage

>>> src/rru_req_if.sv
`timescale 1ns / 1ps

interface rru_req_if;
	logic                        valid;
	logic                        ready;
	logic [rru_pkg::OP_W-1:0]    op;
	logic [rru_pkg::ARCH_W-1:0]  arch_dest;
	logic [rru_pkg::ARCH_W-1:0]  arch_src;
	logic                        src_present;
	logic [rru_pkg::PHYS_W-1:0]  new_phys;
	logic [rru_pkg::PHYS_W-1:0]  old_phys;
	logic                        has_phys;

	modport source (
		output valid, op, arch_dest, arch_src, src_present, new_phys, old_phys, has_phys,
		input  ready
	);
	modport sink (
		input  valid, op, arch_dest, arch_src, src_present, new_phys, old_phys, has_phys,
		output ready
	);
endinterface

>>> src/rru_rsp_if.sv
`timescale 1ns / 1ps

interface rru_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        accepted;
	logic [rru_pkg::PHYS_W-1:0]  src_phys;
	logic [rru_pkg::PHYS_W-1:0]  dest_phys;
	logic [rru_pkg::PHYS_W-1:0]  prev_phys;
	logic                        dest_given;
	logic                        is_ready;

	modport source (
		output valid, accepted, src_phys, dest_phys, prev_phys, dest_given, is_ready,
		input  ready
	);
	modport sink (
		input  valid, accepted, src_phys, dest_phys, prev_phys, dest_given, is_ready,
		output ready
	);
endinterface

>>> src/rru_ram.sv
`timescale 1ns / 1ps

module rru_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr_a,
	input  logic [$clog2(D)-1:0] raddr_b,
	output logic [W-1:0]         rdata_a,
	output logic [W-1:0]         rdata_b
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> src/rru_find_free.sv
`timescale 1ns / 1ps

module rru_find_free #(
	parameter int N = 64
) (
	input  logic [N-1:0]         busy,
	output logic                 found,
	output logic [$clog2(N)-1:0] idx
);

	logic [N-1:0] free;
	logic [N-1:0] lowest;

	assign free   = ~busy;
	assign lowest = free & (~free + N'(1));
	assign found  = |free;

	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (lowest[i]) begin
				idx = idx | ($clog2(N))'(i);
			end
		end
	end

endmodule

>>> src/register_rename_unit.sv
`timescale 1ns / 1ps

// channel | dir | payload                                                     | note
// req     | in  | op arch_dest arch_src src_present new_phys old_phys has_phys | one request/cycle unless stalled
// rsp     | out | accepted src_phys dest_phys prev_phys dest_given is_ready   | one per request
//
// One request per cycle sustained while results are taken; a request is registered in stage 1, its result in stage 2.
// Map lookups go through a registered-read RAM with write forwarding; the
// free search is a single priority encoder over the busy vector.
// Reset takes effect at once: per-entry valid bits make the map read as identity.
// A result not taken holds the stage-1 request and drops req.ready.

module register_rename_unit #(
	parameter int ARCH_REGS = 32,
	parameter int PHYS_REGS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	rru_req_if.sink      req,
	rru_rsp_if.source    rsp
);

	localparam int AW = $clog2(ARCH_REGS);
	localparam int MW = $clog2(PHYS_REGS);
	localparam int XW = (rru_pkg::ARCH_W > $clog2(ARCH_REGS + 1)) ?
		rru_pkg::ARCH_W + 1 : $clog2(ARCH_REGS + 1) + 1;

	function automatic logic [PHYS_REGS-1:0] init_vec();
		logic [PHYS_REGS-1:0] v;
		v = '0;
		for (int i = 0; i < PHYS_REGS; i++) begin
			v[i] = (i < ARCH_REGS);
		end
		return v;
	endfunction

	localparam logic [PHYS_REGS-1:0] INIT_VEC = init_vec();

	logic accept, advance;

	logic [XW-1:0] dest_x, src_x;
	logic          dest_ok_in, src_ok_in;
	logic [AW-1:0] dest_idx_in, src_idx_in;

	logic          map_we;
	logic [AW-1:0] map_waddr;
	logic [MW-1:0] map_wdata;
	logic [MW-1:0] ram_src, ram_dst;

	logic [ARCH_REGS-1:0] vld_q;
	logic [PHYS_REGS-1:0] busy_q, ready_q, cbusy_q;
	logic [PHYS_REGS-1:0] busy_d, ready_d, cbusy_d;
	logic [MW-1:0]        cmap_q [ARCH_REGS];

	logic                     s1_valid;
	rru_pkg::op_t             op_s1;
	logic [AW-1:0]            dest_idx_s1;
	logic                     dest_ok_s1, src_ok_s1, has_phys_s1;
	logic [rru_pkg::PHYS_W-1:0] newp_s1, oldp_s1;
	logic                     src_fwd_s1, dst_fwd_s1, src_vld_s1, dst_vld_s1;
	logic [AW-1:0]            src_idx_s1;
	logic [MW-1:0]            fwd_data_s1;

	logic          free_found;
	logic [MW-1:0] free_idx;
	logic [MW-1:0] src_map, dst_map;
	logic          cmap_we;

	logic          rsp_valid_s2;
	rru_pkg::rsp_t rsp_s2, rsp_d;

	assign advance   = s1_valid && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !s1_valid || advance;
	assign accept    = req.valid && req.ready;

	assign dest_x      = XW'(req.arch_dest);
	assign src_x       = XW'(req.arch_src);
	assign dest_ok_in  = (dest_x != '0) && (dest_x < XW'(ARCH_REGS));
	assign src_ok_in   = req.src_present && (src_x < XW'(ARCH_REGS));
	assign dest_idx_in = dest_x[AW-1:0];
	assign src_idx_in  = src_x[AW-1:0];

	rru_ram #(.W(MW), .D(ARCH_REGS)) u_map (
		.clk     (clk),
		.we      (map_we),
		.waddr   (map_waddr),
		.wdata   (map_wdata),
		.re      (accept),
		.raddr_a (src_idx_in),
		.raddr_b (dest_idx_in),
		.rdata_a (ram_src),
		.rdata_b (ram_dst)
	);

	rru_find_free #(.N(PHYS_REGS)) u_free (
		.busy  (busy_q),
		.found (free_found),
		.idx   (free_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= rru_pkg::op_t'(req.op);
			dest_idx_s1 <= dest_idx_in;
			src_idx_s1  <= src_idx_in;
			dest_ok_s1  <= dest_ok_in;
			src_ok_s1   <= src_ok_in;
			has_phys_s1 <= req.has_phys;
			newp_s1     <= req.new_phys;
			oldp_s1     <= req.old_phys;
			src_fwd_s1  <= map_we && (map_waddr == src_idx_in);
			dst_fwd_s1  <= map_we && (map_waddr == dest_idx_in);
			src_vld_s1  <= src_ok_in && vld_q[src_idx_in];
			dst_vld_s1  <= dest_ok_in && vld_q[dest_idx_in];
			fwd_data_s1 <= map_wdata;
		end
	end

	// unwritten entries read as identity
	assign src_map = src_fwd_s1 ? fwd_data_s1 : (src_vld_s1 ? ram_src : MW'(src_idx_s1));
	assign dst_map = dst_fwd_s1 ? fwd_data_s1 : (dst_vld_s1 ? ram_dst : MW'(dest_idx_s1));

	always_comb begin
		logic [PHYS_REGS-1:0] m_new, m_old, m_free;
		m_new   = PHYS_REGS'(1) << newp_s1;
		m_old   = PHYS_REGS'(1) << oldp_s1;
		m_free  = PHYS_REGS'(1) << free_idx;
		busy_d  = busy_q;
		ready_d = ready_q;
		cbusy_d = cbusy_q;
		rsp_d   = '0;
		map_we    = 1'b0;
		map_waddr = dest_idx_s1;
		map_wdata = free_idx;
		cmap_we   = 1'b0;
		unique case (op_s1)
			rru_pkg::OP_ALLOC: begin
				rsp_d.accepted = 1'b1;
				if (src_ok_s1) begin
					rsp_d.src_phys = src_map[rru_pkg::PHYS_W-1:0];
				end
				if (dest_ok_s1) begin
					rsp_d.prev_phys = dst_map[rru_pkg::PHYS_W-1:0];
					if (!free_found) begin
						rsp_d.accepted = 1'b0;
					end else begin
						busy_d           = busy_q | m_free;
						ready_d          = ready_q & ~m_free;
						map_we           = advance;
						rsp_d.dest_phys  = free_idx[rru_pkg::PHYS_W-1:0];
						rsp_d.dest_given = 1'b1;
					end
				end
			end
			rru_pkg::OP_COMPLETE: begin
				ready_d = ready_q | m_new;
			end
			rru_pkg::OP_RETIRE: begin
				if (dest_ok_s1 && has_phys_s1) begin
					busy_d  = busy_q & ~m_old;
					ready_d = ready_q & ~m_old;
					cbusy_d = (cbusy_q | m_new) & ~m_old;
					cmap_we = advance;
				end
			end
			rru_pkg::OP_ROLLBACK: begin
				if (dest_ok_s1) begin
					map_we    = advance;
					map_wdata = MW'(oldp_s1);
					if (has_phys_s1) begin
						busy_d  = busy_q & ~m_new;
						ready_d = ready_q & ~m_new;
					end
				end
			end
			rru_pkg::OP_QUERY: begin
				rsp_d.is_ready = |(ready_q & m_new);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			busy_q  <= INIT_VEC;
			ready_q <= INIT_VEC;
			cbusy_q <= INIT_VEC;
			for (int i = 0; i < ARCH_REGS; i++) begin
				cmap_q[i] <= MW'(i);
			end
		end else if (advance) begin
			busy_q  <= busy_d;
			ready_q <= ready_d;
			cbusy_q <= cbusy_d;
			if (map_we) begin
				vld_q[map_waddr] <= 1'b1;
			end
			if (cmap_we) begin
				cmap_q[dest_idx_s1] <= MW'(newp_s1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (advance) begin
			rsp_valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid      = rsp_valid_s2;
	assign rsp.accepted   = rsp_s2.accepted;
	assign rsp.src_phys   = rsp_s2.src_phys;
	assign rsp.dest_phys  = rsp_s2.dest_phys;
	assign rsp.prev_phys  = rsp_s2.prev_phys;
	assign rsp.dest_given = rsp_s2.dest_given;
	assign rsp.is_ready   = rsp_s2.is_ready;

	a_given_acc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.dest_given |-> rsp.accepted)
		else $error("dest given without accept");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && map_we && (op_s1 == rru_pkg::OP_ALLOC) |=> busy_q[$past(free_idx)])
		else $error("allocated register not busy");

	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		!free_found |-> &busy_q)
		else $error("free search missed a register");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> s1_valid && rsp_valid_s2 && !rsp.ready)
		else $error("request refused without a stalled result");

endmodule

>>> bench/tb_register_rename_unit.sv
`timescale 1ns / 1ps

module tb_register_rename_unit;
	import rru_pkg::*;

	localparam int ARCH_COUNT = 32;
	localparam int PHYS_COUNT = 64;
	localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
	localparam int PICK_NOISE = 5;
	localparam int MIX_FILL = 0;
	localparam int MIX_COUNT = 4;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 160;
	localparam int WINDOW_MAX = 48;
	localparam int RX_STEADY = 0;
	localparam int RX_CHOPPY = 1;
	localparam int RX_SLOW = 2;
	localparam int HOLD_AT_A = 300;
	localparam int HOLD_AT_B = 2500;
	localparam int HOLD_CYCLES = 100;
	localparam int STUCK_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 16;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ARCH_W-1:0] arch_dest;
		logic [ARCH_W-1:0] arch_src;
		logic              src_present;
		logic [PHYS_W-1:0] new_phys;
		logic [PHYS_W-1:0] old_phys;
		logic              has_phys;
	} rename_req_t;

	// one renamed instruction still in flight, oldest at the front
	typedef struct {
		logic [ARCH_W-1:0] dest;
		logic [PHYS_W-1:0] newp;
		logic [PHYS_W-1:0] oldp;
		logic              has;
	} in_flight_t;

	class rename_scoreboard;
		logic [PHYS_W-1:0]     alias_map[ARCH_COUNT];
		logic [PHYS_COUNT-1:0] busy_bits;
		logic [PHYS_COUNT-1:0] ready_bits;
		rsp_t                  pending[$];
		int                    errors;

		function new();
			for (int i = 0; i < ARCH_COUNT; i++)
				alias_map[i] = PHYS_W'(i);
			busy_bits = {{(PHYS_COUNT-ARCH_COUNT){1'b0}}, {ARCH_COUNT{1'b1}}};
			ready_bits = busy_bits;
			errors = 0;
		endfunction

		function rsp_t note_request(rename_req_t r);
			rsp_t res;
			int slot;
			res = '0;
			slot = PHYS_COUNT;
			case (r.op)
				OP_ALLOC: begin
					if (r.src_present)
						res.src_phys = alias_map[r.arch_src];
					res.accepted = 1'b1;
					if (r.arch_dest != 0) begin
						res.prev_phys = alias_map[r.arch_dest];
						for (int i = PHYS_COUNT - 1; i >= 0; i--)
							if (!busy_bits[i])
								slot = i;
						if (slot == PHYS_COUNT) begin
							res.accepted = 1'b0;
						end else begin
							busy_bits[slot] = 1'b1;
							ready_bits[slot] = 1'b0;
							alias_map[r.arch_dest] = PHYS_W'(slot);
							res.dest_phys = PHYS_W'(slot);
							res.dest_given = 1'b1;
						end
					end
				end
				OP_COMPLETE: ready_bits[r.new_phys] = 1'b1;
				OP_RETIRE: begin
					if (r.arch_dest != 0 && r.has_phys) begin
						busy_bits[r.old_phys] = 1'b0;
						ready_bits[r.old_phys] = 1'b0;
					end
				end
				OP_ROLLBACK: begin
					if (r.arch_dest != 0) begin
						alias_map[r.arch_dest] = r.old_phys;
						if (r.has_phys) begin
							busy_bits[r.new_phys] = 1'b0;
							ready_bits[r.new_phys] = 1'b0;
						end
					end
				end
				OP_QUERY: res.is_ready = ready_bits[r.new_phys];
				default: ;
			endcase
			pending.push_back(res);
			return res;
		endfunction

		function void check_response(rsp_t seen);
			rsp_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: result with nothing outstanding: %p", $time, seen);
				return;
			end
			want = pending.pop_front();
			if (seen.accepted !== want.accepted || seen.src_phys !== want.src_phys ||
					seen.dest_phys !== want.dest_phys || seen.prev_phys !== want.prev_phys ||
					seen.dest_given !== want.dest_given || seen.is_ready !== want.is_ready) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: mismatch exp acc=%0d src=%0d dst=%0d prev=%0d given=%0d rdy=%0d",
						$time, want.accepted, want.src_phys, want.dest_phys, want.prev_phys,
						want.dest_given, want.is_ready);
					$display("%0t:          got acc=%0d src=%0d dst=%0d prev=%0d given=%0d rdy=%0d",
						$time, seen.accepted, seen.src_phys, seen.dest_phys, seen.prev_phys,
						seen.dest_given, seen.is_ready);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rru_req_if req_ch();
	rru_rsp_if rsp_ch();

	register_rename_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	rename_scoreboard board;
	rsp_t last_result;
	in_flight_t window[$];
	int burst_left = 0;
	int stuck_cycles = 0;
	int rx_cycle = 0;
	int hold_left = 0;
	int rx_mode = RX_STEADY;
	int rx_mode_left = 0;

	// alloc, complete, retire, rollback, query, noise
	int weights[MIX_COUNT][6] = '{
		'{70, 10,  5,  0, 10,  5},
		'{35, 20, 25,  5, 10,  5},
		'{30, 10, 15, 30, 10,  5},
		'{20, 10, 10,  5,  5, 50}
	};

	always #4 clk = ~clk;

	function automatic rename_req_t mk(logic [OP_W-1:0] op, int dest, int src, bit sp,
			int newp, int oldp, bit has);
		rename_req_t r;
		r.op = op;
		r.arch_dest = ARCH_W'(dest);
		r.arch_src = ARCH_W'(src);
		r.src_present = sp;
		r.new_phys = PHYS_W'(newp);
		r.old_phys = PHYS_W'(oldp);
		r.has_phys = has;
		return r;
	endfunction

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 40);
		if ($urandom_range(0, 3) != 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send(input rename_req_t r);
		req_ch.valid <= 1'b1;
		req_ch.op <= r.op;
		req_ch.arch_dest <= r.arch_dest;
		req_ch.arch_src <= r.arch_src;
		req_ch.src_present <= r.src_present;
		req_ch.new_phys <= r.new_phys;
		req_ch.old_phys <= r.old_phys;
		req_ch.has_phys <= r.has_phys;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		last_result = board.note_request(r);
		pace();
	endtask

	task automatic random_item(input int mix);
		int draw;
		int kind;
		bit [31:0] w;
		rename_req_t r;
		in_flight_t e;
		w = $urandom;
		r = rename_req_t'(w[$bits(rename_req_t)-1:0]);
		draw = $urandom_range(0, 99);
		kind = 0;
		while (draw >= weights[mix][kind]) begin
			draw -= weights[mix][kind];
			kind++;
		end
		if ((kind == OP_RETIRE || kind == OP_ROLLBACK) && window.size() == 0)
			kind = OP_ALLOC;
		if (window.size() > WINDOW_MAX)
			kind = OP_RETIRE;
		if (kind != PICK_NOISE) begin
			r.op = OP_W'(kind);
			case (r.op)
				OP_ALLOC: r.src_present = ($urandom_range(0, 4) != 0);
				OP_COMPLETE, OP_QUERY: begin
					if (window.size() != 0 && $urandom_range(0, 1) == 1)
						r.new_phys = window[$urandom_range(0, window.size() - 1)].newp;
				end
				OP_RETIRE: begin
					e = window.pop_front();
					r.arch_dest = e.dest;
					r.new_phys = e.newp;
					r.old_phys = e.oldp;
					r.has_phys = e.has;
				end
				OP_ROLLBACK: begin
					e = window.pop_back();
					r.arch_dest = e.dest;
					r.new_phys = e.newp;
					r.old_phys = e.oldp;
					r.has_phys = e.has;
				end
				default: ;
			endcase
		end
		send(r);
		if (r.op == OP_ALLOC && last_result.accepted) begin
			e.dest = r.arch_dest;
			e.newp = last_result.dest_phys;
			e.oldp = last_result.prev_phys;
			e.has = last_result.dest_given;
			window.push_back(e);
		end
	endtask

	// response side: checking, stall pattern, long hold-offs
	always @(posedge clk) begin
		rsp_t seen;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.accepted = rsp_ch.accepted;
			seen.src_phys = rsp_ch.src_phys;
			seen.dest_phys = rsp_ch.dest_phys;
			seen.prev_phys = rsp_ch.prev_phys;
			seen.dest_given = rsp_ch.dest_given;
			seen.is_ready = rsp_ch.is_ready;
			board.check_response(seen);
		end
		rx_cycle++;
		if (rx_cycle == HOLD_AT_A || rx_cycle == HOLD_AT_B)
			hold_left = HOLD_CYCLES;
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(RX_STEADY, RX_SLOW);
			rx_mode_left = $urandom_range(16, 96);
		end
		rx_mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_STEADY: rsp_ch.ready <= 1'b1;
				RX_CHOPPY: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
				default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		board = new();
		req_ch.valid = 1'b0;
		req_ch.op = OP_QUERY;
		req_ch.arch_dest = '0;
		req_ch.arch_src = '0;
		req_ch.src_present = 1'b0;
		req_ch.new_phys = '0;
		req_ch.old_phys = '0;
		req_ch.has_phys = 1'b0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));
		send(mk(OP_QUERY, 0, 0, 0, 32, 0, 0));
		send(mk(OP_ALLOC, 1, 0, 1, 0, 0, 0));
		send(mk(OP_ALLOC, 31, 1, 1, 63, 63, 1));
		send(mk(OP_ALLOC, 0, 31, 1, 0, 0, 0));
		send(mk(OP_ALLOC, 5, 7, 0, 0, 0, 0));
		send(mk(OP_QUERY, 0, 0, 0, 33, 0, 0));
		send(mk(OP_COMPLETE, 0, 0, 0, 33, 0, 0));
		send(mk(OP_QUERY, 0, 0, 0, 33, 0, 0));
		send(mk(OP_RETIRE, 1, 0, 0, 32, 1, 1));
		send(mk(OP_RETIRE, 0, 0, 0, 63, 2, 1));
		send(mk(OP_RETIRE, 5, 0, 0, 34, 5, 0));
		send(mk(OP_ROLLBACK, 5, 0, 0, 34, 5, 0));
		send(mk(OP_ROLLBACK, 0, 0, 0, 33, 31, 1));
		send(mk(OP_ROLLBACK, 31, 0, 0, 33, 31, 1));
		send(mk(OP_ALLOC, 2, 31, 1, 0, 0, 0));
		send(mk(OP_COMPLETE, 0, 0, 0, 63, 0, 0));
		send(mk(OP_QUERY, 31, 31, 1, 63, 63, 1));
		send(mk(OP_QUERY, 0, 0, 0, 1, 0, 0));
		for (int c = OP_RSVD_LO; c <= OP_RSVD_HI; c++)
			send(mk(OP_W'(c), 31, 31, 1, 63, 63, 1));
		send(mk(OP_ALLOC, 31, 31, 1, 63, 63, 1));

		for (int phase = 0; phase < PHASES; phase++) begin
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item(phase == 0 ? MIX_FILL : $urandom_range(0, MIX_COUNT - 1));
			if (phase == 4 || $urandom_range(0, 2) == 0) begin
				req_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while (board.pending.size() != 0);
			end
		end

		req_ch.valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> sim.f
src/rru_pkg.sv
src/rru_req_if.sv
src/rru_rsp_if.sv
src/rru_ram.sv
src/rru_find_free.sv
src/register_rename_unit.sv
bench/tb_register_rename_unit.sv
